// File: rtl/tab_stop_bitmap_unit_assert.svh
// ----------------------------------------------------------------------------
// Tab stop bitmap assertion macros
// Shared forms for the concurrent checks of the tab stop bitmap unit.
// ----------------------------------------------------------------------------
`ifndef TAB_STOP_BITMAP_UNIT_ASSERT_SVH
`define TAB_STOP_BITMAP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tab stop bitmap check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tab stop bitmap check failed");

`endif

// File: rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// Tab stop bitmap package
// Types and constants shared by the cells, the channels and the top level.
// ----------------------------------------------------------------------------
package tsb_pkg;

	// Number of table bytes, each holding eight columns.
	localparam int TABLE_BYTES = 10;
	localparam int CELL_W      = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
	localparam int COL_W       = 7;
	localparam int CMP_W       = 8;

	typedef enum logic [1:0] {
		OP_CLEAR_ALL = 2'd0,
		OP_SET       = 2'd1,
		OP_CLEAR     = 2'd2,
		OP_FIND      = 2'd3
	} op_t;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [CELL_W-1:0] cell_idx_t;

	// Table update broadcast to every cell at once.
	typedef struct packed {
		logic en;
		op_t  op;
		col_t column;
	} wr_cmd_t;

	// Search token handed from cell to cell during a find.
	typedef struct packed {
		logic active;
		logic found;
		col_t column;
		col_t result;
	} token_t;

endpackage

// File: rtl/tsb_cmd_if.sv
// ----------------------------------------------------------------------------
// Tab stop bitmap command channel
// Valid/ready channel carrying an operation code and a cursor column.
// ----------------------------------------------------------------------------
interface tsb_cmd_if import tsb_pkg::*;;
	logic valid;
	logic ready;
	op_t  op;
	col_t column;

	modport source (output valid, output op, output column, input ready);
	modport sink (input valid, input op, input column, output ready);
endinterface

// File: rtl/tsb_rsp_if.sv
// ----------------------------------------------------------------------------
// Tab stop bitmap response channel
// Valid/ready channel carrying the resulting column and the found flag.
// ----------------------------------------------------------------------------
interface tsb_rsp_if import tsb_pkg::*;;
	logic valid;
	logic ready;
	col_t next_column;
	logic found;

	modport source (output valid, output next_column, output found, input ready);
	modport sink (input valid, input next_column, input found, output ready);
endinterface

// File: rtl/tsb_cell.sv
// ----------------------------------------------------------------------------
// Tab stop bitmap cell
// Holds one table byte, applies broadcast updates and passes the search
// token on to the next cell, claiming it when its byte has a qualifying stop.
// ----------------------------------------------------------------------------
module tsb_cell import tsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_idx_t idx,
	input  wr_cmd_t   wr,
	input  token_t    tok_in,
	output token_t    tok_out
);

	logic [7:0]       byte_q;
	token_t           tok_q;
	token_t           tok_d;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] wr_byte;
	logic [CMP_W-1:0] tok_byte;
	logic [7:0]       wr_mask;
	logic [7:0]       start_mask;
	logic [7:0]       cand;
	logic [2:0]       pos;
	logic [CMP_W-1:0] hit_col;

	assign idx_ext  = CMP_W'(idx);
	assign wr_byte  = CMP_W'(wr.column[COL_W-1:3]);
	assign tok_byte = CMP_W'(tok_in.column[COL_W-1:3]);
	assign wr_mask  = 8'h80 >> wr.column[2:0];

	// Bytes below the start byte are skipped; the start byte from its bit on.
	always_comb begin
		if (idx_ext < tok_byte) begin
			start_mask = 8'h00;
		end else if (idx_ext == tok_byte) begin
			start_mask = 8'hFF >> tok_in.column[2:0];
		end else begin
			start_mask = 8'hFF;
		end
	end

	assign cand = byte_q & start_mask;

	// Lowest column wins: the most significant set bit.
	always_comb begin
		pos = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (cand[7-b]) begin
				pos = 3'(b);
			end
		end
	end

	assign hit_col = CMP_W'({idx, pos}) + CMP_W'(1);

	// The token passes on unchanged unless this cell claims it.
	always_comb begin
		tok_d = tok_in;
		if (tok_in.active && !tok_in.found && (cand != 8'h00)) begin
			tok_d.found  = 1'b1;
			tok_d.result = hit_col[COL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (wr.en) begin
			case (wr.op)
				OP_CLEAR_ALL: byte_q <= 8'h00;
				OP_SET: begin
					if (wr_byte == idx_ext) begin
						byte_q <= byte_q | wr_mask;
					end
				end
				OP_CLEAR: begin
					if (wr_byte == idx_ext) begin
						byte_q <= byte_q & ~wr_mask;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: rtl/tab_stop_bitmap_unit.sv
// ----------------------------------------------------------------------------
// Tab stop bitmap unit
// Keeps one tab stop bit per column and answers set, clear and find requests.
//
// Commands arrive on the cmd channel (op, column) and each one produces
// exactly one transaction on the rsp channel (next_column, found).
// The table is a row of cells, one per table byte. Clear all, set stop and
// clear stop act on every cell in the cycle the command is accepted and
// their response, the column echoed with found low, is offered in the next
// cycle. A find launches a search token into the first cell; the token moves
// one cell per cycle and is claimed by the first cell holding a stop at or
// after the column. A find is answered from the output register once the
// token has left the last cell, whether a stop is found or not. While the
// token walks the row the cmd channel is blocked: one command at a time.
// The result sits in an output register. A new command is taken while a
// result waits only if the receiver takes that result in the same cycle; a
// stalled receiver holds the result and blocks the cmd channel. Reset
// clears every stop at once and empties the output register.
// ----------------------------------------------------------------------------
`include "tab_stop_bitmap_unit_assert.svh"

module tab_stop_bitmap_unit import tsb_pkg::*; (
	input logic clk,
	input logic arst_n,
	tsb_cmd_if.sink   cmd,
	tsb_rsp_if.source rsp
);

	// Token chain: entry 0 is the launch, the last entry leaves the final cell.
	token_t  tok [TABLE_BYTES+1];
	wr_cmd_t wr;
	logic    cmd_acc;
	logic    scan_active_q;
	logic    out_valid_q;
	col_t    out_col_q;
	logic    out_found_q;

	// The unit is free when no find is walking the row and the output register
	// is empty or being emptied in this cycle.
	assign cmd.ready = !scan_active_q && (!out_valid_q || rsp.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	// Table updates go to every cell; each cell decides whether the column is its own.
	assign wr.en     = cmd_acc && (cmd.op != OP_FIND);
	assign wr.op     = cmd.op;
	assign wr.column = cmd.column;

	// A find starts with no stop found and the column as the fallback answer.
	assign tok[0].active = cmd_acc && (cmd.op == OP_FIND);
	assign tok[0].found  = 1'b0;
	assign tok[0].column = cmd.column;
	assign tok[0].result = cmd.column;

	for (genvar g = 0; g < TABLE_BYTES; g++) begin : g_cell
		tsb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (CELL_W'(g)),
			.wr      (wr),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
		end else if (tok[0].active) begin
			scan_active_q <= 1'b1;
		end else if (tok[TABLE_BYTES].active) begin
			scan_active_q <= 1'b0;
		end
	end

	// Output register: loaded by the token leaving the row, or directly by an
	// update command; emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok[TABLE_BYTES].active || wr.en) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[TABLE_BYTES].active) begin
			out_col_q   <= tok[TABLE_BYTES].result;
			out_found_q <= tok[TABLE_BYTES].found;
		end else if (wr.en) begin
			out_col_q   <= cmd.column;
			out_found_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.next_column = out_col_q;
	assign rsp.found       = out_found_q;

	// A search in flight never shares the unit with a held result.
	`TSB_ASSERT_SAME(a_scan_no_result, clk, arst_n, scan_active_q, !out_valid_q)
	// The token can only leave the row while a find is registered as running.
	`TSB_ASSERT_SAME(a_token_in_scan, clk, arst_n, tok[TABLE_BYTES].active, scan_active_q)
	// An update command is answered in the very next cycle.
	`TSB_ASSERT_NEXT(a_update_answer, clk, arst_n, wr.en, out_valid_q && !out_found_q)

endmodule
